### rtl/dops_pkg.sv
package dops_pkg;

  // table geometry
  localparam int NUM_POINTS  = 8;
  localparam int TABLE_SLOTS = 16;
  localparam int SCAN_TOP    = (NUM_POINTS - 1) % TABLE_SLOTS;

  // field widths
  localparam int KHZ_W   = 19;
  localparam int MV_W    = 11;
  localparam int IDX_W   = 4;
  localparam int PT_W    = 3;
  localparam int STEP_W  = 3;
  localparam int GAIN_W  = 4;
  localparam int DUTY_W  = 16;

  // reset values
  localparam logic [STEP_W-1:0]  MAX_STEP_RST  = 3'd2;
  localparam logic [MV_W-1:0]    VMAX_RST      = 11'd1320;
  localparam logic [GAIN_W-1:0]  DUTY_GAIN_RST = 4'd2;
  localparam logic [PT_W-1:0]    CUR_POINT_RST = 3'd3;
  localparam logic [MV_W-1:0]    CUR_VOLT_RST  = 11'd1100;

  // divide by five: (x * 205) >> 10 is exact for x below 1024
  localparam logic [7:0] DIV5_MUL   = 8'd205;
  localparam int         DIV5_SHIFT = 10;

  // register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  typedef enum logic [1:0] {
    REG_MAX_STEP  = 2'd0,
    REG_VMAX_MV   = 2'd1,
    REG_DUTY_GAIN = 2'd2
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [STEP_W-1:0]  max_step;
    logic [MV_W-1:0]    vmax_mv;
    logic [GAIN_W-1:0]  duty_gain;
  } cfg_t;

  // operating point decision
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KHZ_W-1:0] khz;
    logic [MV_W-1:0]  volt;
    logic             changed;
    logic             trend;
    logic             limited;
  } sel_t;

  // operating point frequencies, slots past the last point repeat it
  function automatic logic [KHZ_W-1:0] point_khz(input logic [IDX_W-1:0] idx);
    logic [KHZ_W-1:0] f;
    unique case (idx)
      4'd0:    f = 19'd432000;
      4'd1:    f = 19'd400000;
      4'd2:    f = 19'd375000;
      4'd3:    f = 19'd345600;
      4'd4:    f = 19'd300000;
      4'd5:    f = 19'd250000;
      4'd6:    f = 19'd200000;
      default: f = 19'd150000;
    endcase
    return f;
  endfunction

  // operating point voltages
  function automatic logic [MV_W-1:0] point_mv(input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    unique case (idx)
      4'd0:                      v = 11'd1300;
      4'd1, 4'd2:                v = 11'd1200;
      4'd3, 4'd4, 4'd5, 4'd6:    v = 11'd1100;
      default:                   v = 11'd1050;
    endcase
    return v;
  endfunction

endpackage

### rtl/dvfs_operating_point_selector.sv
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_requested_khz
//  out_     output     out_valid / out_stall  point, freq, volt, flags, duty
//  cfg      input      psel/penable/pwrite    paddr, pwdata, prdata
//
//  one item per cycle unless stalled; out_valid marks an item in the output register
//  the table lookup, clamp and duty math sit between the input and output registers
//  current point and voltage update when an item moves into the output register
//  out_stall holds the output register; the input register refills as it drains
//  rst_n is synchronous; current point resets to 3 (345600 kHz), voltage to 1100 mV
module dvfs_operating_point_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dops_pkg::KHZ_W-1:0]    in_requested_khz,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dops_pkg::PT_W-1:0]     out_point_index,
  output logic [dops_pkg::KHZ_W-1:0]    out_granted_khz,
  output logic [dops_pkg::MV_W-1:0]     out_volt_mv,
  output logic                          out_volt_changed,
  output logic                          out_trend_up,
  output logic                          out_step_limited,
  output logic [dops_pkg::DUTY_W-1:0]   out_pwm_duty,
  output logic                          out_duty_saturated,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dops_pkg::ADDR_W-1:0]   paddr,
  input  logic [dops_pkg::DATA_W-1:0]   pwdata,
  output logic [dops_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  dops_pkg::cfg_t              cfg;
  dops_pkg::sel_t              sel;
  logic [dops_pkg::DUTY_W-1:0] duty;
  logic                        duty_sat;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [dops_pkg::KHZ_W-1:0]  s1_khz_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [dops_pkg::PT_W-1:0]   cur_point_r, cur_point_nxt;
  logic [dops_pkg::MV_W-1:0]   cur_volt_r, cur_volt_nxt;
  logic                        advance;
  logic                        in_acc;
  logic                        xfer;

  logic [dops_pkg::PT_W-1:0]   o_point_r;
  logic [dops_pkg::KHZ_W-1:0]  o_khz_r;
  logic [dops_pkg::MV_W-1:0]   o_volt_r;
  logic                        o_changed_r;
  logic                        o_trend_r;
  logic                        o_limited_r;
  logic [dops_pkg::DUTY_W-1:0] o_duty_r;
  logic                        o_sat_r;

  dops_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dops_select u_select (
    .req_khz   (s1_khz_r),
    .cur_point (cur_point_r),
    .cur_volt  (cur_volt_r),
    .max_step  (cfg.max_step),
    .sel       (sel)
  );

  dops_duty u_duty (
    .volt      (sel.volt),
    .vmax_mv   (cfg.vmax_mv),
    .duty_gain (cfg.duty_gain),
    .duty      (duty),
    .saturated (duty_sat)
  );

  // pipeline flow control
  assign advance  = !out_valid_r || !out_stall;
  assign xfer     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)
      s1_valid_nxt = 1'b1;
    else if (xfer)
      s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)
      out_valid_nxt = s1_valid_r;
  end

  // operating point state follows each item that completes
  always_comb begin
    cur_point_nxt = cur_point_r;
    cur_volt_nxt  = cur_volt_r;
    if (xfer) begin
      cur_point_nxt = sel.idx[dops_pkg::PT_W-1:0];
      cur_volt_nxt  = sel.volt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_point_r <= dops_pkg::CUR_POINT_RST;
      cur_volt_r  <= dops_pkg::CUR_VOLT_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cur_point_r <= cur_point_nxt;
      cur_volt_r  <= cur_volt_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc)
      s1_khz_r <= in_requested_khz;
  end

  // result register
  always_ff @(posedge clk) begin
    if (xfer) begin
      o_point_r   <= sel.idx[dops_pkg::PT_W-1:0];
      o_khz_r     <= sel.khz;
      o_volt_r    <= sel.volt;
      o_changed_r <= sel.changed;
      o_trend_r   <= sel.trend;
      o_limited_r <= sel.limited;
      o_duty_r    <= duty;
      o_sat_r     <= duty_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_point_index    = o_point_r;
  assign out_granted_khz    = o_khz_r;
  assign out_volt_mv        = o_volt_r;
  assign out_volt_changed   = o_changed_r;
  assign out_trend_up       = o_trend_r;
  assign out_step_limited   = o_limited_r;
  assign out_pwm_duty       = o_duty_r;
  assign out_duty_saturated = o_sat_r;

endmodule

### rtl/dops_regs.sv
module dops_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dops_pkg::ADDR_W-1:0]  paddr,
  input  logic [dops_pkg::DATA_W-1:0]  pwdata,
  output logic [dops_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output dops_pkg::cfg_t               cfg
);

  logic [dops_pkg::STEP_W-1:0]  max_step_r,  max_step_nxt;
  logic [dops_pkg::MV_W-1:0]    vmax_r,      vmax_nxt;
  logic [dops_pkg::GAIN_W-1:0]  duty_gain_r, duty_gain_nxt;
  logic                         wr_en;
  logic [1:0]                   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register write decode
  always_comb begin
    max_step_nxt  = max_step_r;
    vmax_nxt      = vmax_r;
    duty_gain_nxt = duty_gain_r;
    if (wr_en) begin
      unique case (reg_sel)
        dops_pkg::REG_MAX_STEP:  max_step_nxt  = pwdata[dops_pkg::STEP_W-1:0];
        dops_pkg::REG_VMAX_MV:   vmax_nxt      = pwdata[dops_pkg::MV_W-1:0];
        dops_pkg::REG_DUTY_GAIN: duty_gain_nxt = pwdata[dops_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r  <= dops_pkg::MAX_STEP_RST;
      vmax_r      <= dops_pkg::VMAX_RST;
      duty_gain_r <= dops_pkg::DUTY_GAIN_RST;
    end else begin
      max_step_r  <= max_step_nxt;
      vmax_r      <= vmax_nxt;
      duty_gain_r <= duty_gain_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      dops_pkg::REG_MAX_STEP:  prdata = dops_pkg::DATA_W'(max_step_r);
      dops_pkg::REG_VMAX_MV:   prdata = dops_pkg::DATA_W'(vmax_r);
      dops_pkg::REG_DUTY_GAIN: prdata = dops_pkg::DATA_W'(duty_gain_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.max_step  = max_step_r;
  assign cfg.vmax_mv   = vmax_r;
  assign cfg.duty_gain = duty_gain_r;

endmodule

### rtl/dops_select.sv
module dops_select (
  input  logic [dops_pkg::KHZ_W-1:0]  req_khz,
  input  logic [dops_pkg::PT_W-1:0]   cur_point,
  input  logic [dops_pkg::MV_W-1:0]   cur_volt,
  input  logic [dops_pkg::STEP_W-1:0] max_step,
  output dops_pkg::sel_t              sel
);

  logic [dops_pkg::IDX_W-1:0] scan_idx;
  logic [dops_pkg::IDX_W-1:0] cur;
  logic [dops_pkg::IDX_W-1:0] step;
  logic [dops_pkg::IDX_W-1:0] hi_lim;
  logic [dops_pkg::IDX_W:0]   scan_plus;
  logic [dops_pkg::IDX_W-1:0] idx;
  logic                       limited;

  // slowest point that still meets the request, fastest point as fallback
  always_comb begin
    scan_idx = '0;
    for (int i = 1; i <= dops_pkg::SCAN_TOP; i++) begin
      if (dops_pkg::point_khz(dops_pkg::IDX_W'(i)) >= req_khz)
        scan_idx = dops_pkg::IDX_W'(i);
    end
  end

  assign cur       = dops_pkg::IDX_W'(cur_point);
  assign step      = dops_pkg::IDX_W'(max_step);
  assign hi_lim    = cur + step;
  assign scan_plus = {1'b0, scan_idx} + {1'b0, step};

  // clamp the move around the current point
  always_comb begin
    idx     = scan_idx;
    limited = 1'b0;
    priority if (scan_idx > hi_lim) begin
      idx     = hi_lim;
      limited = 1'b1;
    end else if (scan_plus < {1'b0, cur}) begin
      idx     = cur - step;
      limited = 1'b1;
    end
  end

  assign sel.idx     = idx;
  assign sel.khz     = dops_pkg::point_khz(idx);
  assign sel.volt    = dops_pkg::point_mv(idx);
  assign sel.changed = (dops_pkg::point_mv(idx) != cur_volt);
  assign sel.trend   = (dops_pkg::point_khz(idx) > dops_pkg::point_khz(cur));
  assign sel.limited = limited;

endmodule

### rtl/dops_duty.sv
module dops_duty (
  input  logic [dops_pkg::MV_W-1:0]    volt,
  input  logic [dops_pkg::MV_W-1:0]    vmax_mv,
  input  logic [dops_pkg::GAIN_W-1:0]  duty_gain,
  output logic [dops_pkg::DUTY_W-1:0]  duty,
  output logic                         saturated
);

  logic [dops_pkg::MV_W-1:0] diff;
  logic [18:0]               recip_prod;
  logic [7:0]                steps;
  logic [11:0]               counts;

  // headroom below vmax in whole 5 mV steps
  assign saturated  = (volt >= vmax_mv);
  assign diff       = vmax_mv - volt;
  assign recip_prod = 19'(diff) * 19'(dops_pkg::DIV5_MUL);
  assign steps      = recip_prod[dops_pkg::DIV5_SHIFT +: 8];
  assign counts     = 12'(steps) * 12'(duty_gain);

  // duty is counts minus one, floored at zero, and zero when saturated
  always_comb begin
    duty = '0;
    if (!saturated && counts != 12'd0)
      duty = dops_pkg::DUTY_W'(counts - 12'd1);
  end

endmodule

### rtl/dops_checker.sv
module dops_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dops_pkg::PT_W-1:0]     out_point_index,
  input logic [dops_pkg::KHZ_W-1:0]    out_granted_khz,
  input logic [dops_pkg::MV_W-1:0]     out_volt_mv,
  input logic [dops_pkg::DUTY_W-1:0]   out_pwm_duty,
  input logic                          out_duty_saturated
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_khz)
      && $stable(out_pwm_duty) && $stable(out_point_index))
    else $error("result changed while stalled");

  // saturated duty reads as zero
  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_duty_saturated |-> out_pwm_duty == '0)
    else $error("saturated duty not zero");

  // fastest point carries the top table entry
  a_fast_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_index == 3'd0 |->
      out_granted_khz == 19'd432000 && out_volt_mv == 11'd1300)
    else $error("fastest point mismatch");

  // slowest point carries the bottom table entry
  a_slow_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_index == 3'd7 |->
      out_granted_khz == 19'd150000 && out_volt_mv == 11'd1050)
    else $error("slowest point mismatch");

endmodule

bind dvfs_operating_point_selector dops_checker u_dops_checker (.*);
